// ===== sv/gcts_pkg.sv =====
// Shared types and constants for the glyph codepoint table search block.
package gcts_pkg;

  localparam int CP_W  = 21;   // codepoint width
  localparam int IDX_W = 13;   // entry index and match index width
  localparam int CNT_W = 14;   // entry count register width

  // configuration register indexes
  localparam logic [0:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [0:0] CFG_LAYOUT_MODE = 1'b1;

  // input word modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // table layouts
  localparam logic LAYOUT_SORTED = 1'b0;
  localparam logic LAYOUT_TREE   = 1'b1;

  // lookup sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_PROBE = 6'b000100,
    S_BSRCH = 6'b001000,
    S_TREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// ===== sv/gcts_ram.sv =====
// Codepoint table storage: one write port, one registered read port.
module gcts_ram
  import gcts_pkg::*;
#(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [CP_W-1:0] wr_data,
  input  logic [AW-1:0]   rd_addr,
  output logic [CP_W-1:0] rd_data
);

  logic [CP_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/glyph_codepoint_table_search_top.sv =====
// Top level of the glyph codepoint table search block.
//
// A write word stores one codepoint into the table in the cycle it is taken;
// while no lookup runs, writes can follow each other every cycle. A lookup
// word runs a sequencer that reads the table RAM once per cycle (one
// registered read port), so its cost is the number of probes: in sorted
// layout it reads entry 0, the direct probe, then a binary search of
// [0, probe]; in tree layout it walks at most ceil(log2(n+1)) levels from
// the root, where n is the entry count. An empty table answers without
// reading the table. One lookup is in flight at a time; a finished result
// sits in the output register, and the next word is taken while it waits.
// The table holds no reset value: look up only entries that were written.
module glyph_codepoint_table_search_top
  import gcts_pkg::*;
#(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata,
  // input words
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [CP_W-1:0]  in_codepoint,
  // result words
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [IDX_W-1:0] out_match_index
);

  localparam int AW = $clog2(TABLE_DEPTH);        // table address
  localparam int NW = $clog2(TABLE_DEPTH + 1);    // count 0..TABLE_DEPTH
  localparam int KW = AW + 2;                     // tree child index

  // configuration registers
  logic [CNT_W-1:0] entry_count_r;
  logic             layout_mode_r;

  // sequencer registers
  state_t          state_r, state_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [NW-1:0]   lo_r, lo_nxt;
  logic [NW-1:0]   hi_r, hi_nxt;
  logic            hit_r, hit_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  logic [IDX_W-1:0] out_index_r;

  logic              in_acc;
  logic              wr_en;
  logic [CP_W-1:0]   rd_data;
  logic [NW-1:0]     n_sat;
  logic [NW-1:0]     nm1;
  logic [CP_W-1:0]   diff;
  logic [NW-1:0]     lo_c, hi_c;
  logic [NW:0]       mid_sum;
  logic [KW-1:0]     k_next;
  logic              out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // drop writes beyond the table
  assign wr_en = in_acc && (in_mode == MODE_WRITE) &&
                 (32'(in_entry_index) < 32'(TABLE_DEPTH));

  // saturate the entry count at the table depth
  assign n_sat = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                         : NW'(entry_count_r);
  assign nm1   = n_r - NW'(1);
  assign diff  = cp_r - rd_data;

  gcts_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_codepoint),
    .rd_addr (addr_nxt),
    .rd_data (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      layout_mode_r <= LAYOUT_SORTED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata;
        CFG_LAYOUT_MODE: layout_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // lookup sequencer: each cycle consumes the word read at addr_r
  // and issues the next read at addr_nxt
  always_comb begin
    state_nxt = state_r;
    cp_nxt    = cp_r;
    n_nxt     = n_r;
    addr_nxt  = addr_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    hit_nxt   = hit_r;
    pos_nxt   = pos_r;
    lo_c      = lo_r;
    hi_c      = hi_r;
    mid_sum   = '0;
    k_next    = '0;

    case (state_r)
      S_IDLE: begin
        addr_nxt = '0;
        if (in_acc && in_mode == MODE_LOOKUP) begin
          cp_nxt   = in_codepoint;
          n_nxt    = n_sat;
          hit_nxt  = 1'b0;
          pos_nxt  = '0;
          if (n_sat == '0) begin
            state_nxt = S_DONE;
          end else if (layout_mode_r == LAYOUT_TREE) begin
            state_nxt = S_TREE;
          end else begin
            state_nxt = S_FIRST;
          end
        end
      end

      // entry 0 is in: pick the direct probe position
      S_FIRST: begin
        if (cp_r >= rd_data && 32'(diff) < 32'(nm1)) begin
          addr_nxt = AW'(diff);
        end else begin
          addr_nxt = AW'(nm1);
        end
        state_nxt = S_PROBE;
      end

      // check the probe, else start the binary search on [0, probe]
      S_PROBE: begin
        if (rd_data == cp_r) begin
          hit_nxt   = 1'b1;
          pos_nxt   = addr_r;
          state_nxt = S_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = NW'(addr_r) + NW'(1);
          addr_nxt  = addr_r >> 1;
          state_nxt = S_BSRCH;
        end
      end

      // binary search, hi is exclusive
      S_BSRCH: begin
        if (rd_data == cp_r) begin
          hit_nxt   = 1'b1;
          pos_nxt   = addr_r;
          state_nxt = S_DONE;
        end else begin
          if (rd_data < cp_r) begin
            lo_c = NW'(addr_r) + NW'(1);
          end else begin
            hi_c = NW'(addr_r);
          end
          lo_nxt  = lo_c;
          hi_nxt  = hi_c;
          mid_sum = {1'b0, lo_c} + {1'b0, hi_c} - (NW+1)'(1);
          if (lo_c >= hi_c) begin
            state_nxt = S_DONE;
          end else begin
            addr_nxt = AW'(mid_sum >> 1);
          end
        end
      end

      // implicit tree walk: children of k at 2k+1 and 2k+2
      S_TREE: begin
        if (rd_data == cp_r) begin
          hit_nxt   = 1'b1;
          pos_nxt   = addr_r;
          state_nxt = S_DONE;
        end else begin
          if (rd_data < cp_r) begin
            k_next = {1'b0, addr_r, 1'b0} + KW'(2);
          end else begin
            k_next = {1'b0, addr_r, 1'b1};
          end
          if (k_next >= KW'(n_r)) begin
            state_nxt = S_DONE;
          end else begin
            addr_nxt = AW'(k_next);
          end
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          addr_nxt  = '0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    n_r    <= n_nxt;
    addr_r <= addr_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    hit_r  <= hit_nxt;
    pos_r  <= pos_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_found_r <= hit_r;
      out_index_r <= hit_r ? IDX_W'(pos_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;

  // binary search reads stay inside the live window
  a_bsrch_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BSRCH) |-> (lo_r <= NW'(addr_r)) && (NW'(addr_r) < hi_r))
    else $error("binary search address outside [lo, hi)");

  // tree walk reads stay below the entry count
  a_tree_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TREE) |-> (NW'(addr_r) < n_r))
    else $error("tree walk address at or above entry count");

  // a sorted lookup never skips the direct probe
  a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BSRCH) |-> ($past(state_r) == S_PROBE || $past(state_r) == S_BSRCH))
    else $error("binary search entered without probe");

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_index == '0))
    else $error("miss carries a nonzero match index");

  // an empty table answers without touching the table
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_LOOKUP && n_sat == '0) |=> (state_r == S_DONE))
    else $error("empty table lookup did not finish at once");

endmodule

// ===== bench/glyph_codepoint_table_search_top_tb.sv =====
// Testbench for the glyph codepoint table search block, with its own search predictor.
module glyph_codepoint_table_search_top_tb
  import gcts_pkg::*;
();

  localparam int TABLE_DEPTH = 8192;
  localparam int MAX_CP      = 'h10FFFF;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_WAIT = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int FULL_PREFIX = 40;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } lookup_answer_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic             in_mode;
  logic [IDX_W-1:0] in_entry_index;
  logic [CP_W-1:0]  in_codepoint;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_found;
  logic [IDX_W-1:0] out_match_index;

  // shadow of the table and registers, updated in word order
  logic [CP_W-1:0]  codepoint_shadow [TABLE_DEPTH];
  logic [CNT_W-1:0] entry_count_q;
  logic             layout_q;
  lookup_answer_t   pending_answers [$];
  lookup_answer_t   oldest_answer;

  // stimulus scratch: ascending values and the order they are stored in
  logic [CP_W-1:0]  sorted_vals [TABLE_DEPTH];
  logic [CP_W-1:0]  layout_vals [TABLE_DEPTH];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  int unsigned holds_served = 0;
  int unsigned items_sent;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  glyph_codepoint_table_search_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_entry_index  (in_entry_index),
    .in_codepoint    (in_codepoint),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_match_index (out_match_index)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // sorted layout: direct probe, then binary search of 0..probe
  function automatic int sorted_search(int unsigned n, int unsigned cp);
    int unsigned first_cp;
    int unsigned probe;
    int lo;
    int hi;
    int mid;
    first_cp = codepoint_shadow[0];
    probe = n - 1;
    if (cp >= first_cp && cp - first_cp < probe) probe = cp - first_cp;
    if (codepoint_shadow[probe] == cp) return int'(probe);
    lo = 0;
    hi = int'(probe);
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (codepoint_shadow[mid] == cp) return mid;
      if (codepoint_shadow[mid] < cp) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  // implicit tree layout: children of k sit at 2k+1 and 2k+2
  function automatic int tree_walk(int unsigned n, int unsigned cp);
    int unsigned k;
    k = 0;
    while (k < n) begin
      if (codepoint_shadow[k] == cp) return int'(k);
      k = (codepoint_shadow[k] < cp) ? 2 * k + 2 : 2 * k + 1;
    end
    return -1;
  endfunction

  function automatic lookup_answer_t answer_lookup(logic [CP_W-1:0] cp);
    int unsigned n;
    int pos;
    lookup_answer_t a;
    n = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : entry_count_q;
    if (n == 0) pos = -1;
    else if (layout_q == LAYOUT_SORTED) pos = sorted_search(n, cp);
    else pos = tree_walk(n, cp);
    a.found = (pos >= 0);
    a.match_index = (pos >= 0) ? IDX_W'(pos) : '0;
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // compare each taken result word with the oldest pending answer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no lookup pending", out_found, 0);
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_found !== oldest_answer.found)
          report_mismatch("found", out_found, oldest_answer.found);
        if (out_match_index !== oldest_answer.match_index)
          report_mismatch("match_index", out_match_index, oldest_answer.match_index);
      end
    end
  end

  // count cycles with no traffic at all and stop a hung run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("glyph_codepoint_table_search_top verification failed");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  always begin
    @(negedge clk);
    if (hold_requests != holds_served) begin
      holds_served++;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one word, hold it until taken, then update the shadow
  task automatic send_word(logic mode, logic [IDX_W-1:0] idx, logic [CP_W-1:0] cp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= idx;
    in_codepoint   <= cp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (mode == MODE_WRITE) codepoint_shadow[idx] = cp;
    else pending_answers.push_back(answer_lookup(cp));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_lookup(logic [CP_W-1:0] cp);
    send_word(MODE_LOOKUP, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), cp);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // write both registers once the block has gone quiet
  task automatic program_config(int count, logic layout);
    wait_results_drained();
    repeat (SETTLE_WAIT) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_wdata <= CNT_W'(count);
    @(negedge clk);
    entry_count_q = CNT_W'(count);
    cfg_index <= CFG_LAYOUT_MODE;
    cfg_wdata <= CNT_W'(layout);
    @(negedge clk);
    layout_q = layout;
    cfg_we <= 1'b0;
  endtask

  // place sorted_vals[0..n-1] into layout_vals in implicit tree order
  task automatic arrange_tree(int n);
    int stack_k [32];
    int sp;
    int k;
    int pos;
    sp = 0;
    k = 0;
    pos = 0;
    while (k < n || sp > 0) begin
      if (k < n) begin
        stack_k[sp] = k;
        sp++;
        k = 2 * k + 1;
      end else begin
        sp--;
        k = stack_k[sp];
        layout_vals[k] = sorted_vals[pos];
        pos++;
        k = 2 * k + 2;
      end
    end
  endtask

  // build ascending values, arrange them, optionally scramble a few, write all n
  task automatic load_table(int n, bit tree, int spread, bit noisy);
    int unsigned v;
    int i;
    int idx;
    bit down;
    v = $urandom_range(0, MAX_CP - n * spread);
    for (i = 0; i < n; i++) begin
      sorted_vals[i] = CP_W'(v);
      v += $urandom_range(1, spread);
    end
    if (tree) begin
      arrange_tree(n);
    end else begin
      for (i = 0; i < n; i++) layout_vals[i] = sorted_vals[i];
    end
    if (noisy) begin
      repeat ($urandom_range(1, 3))
        layout_vals[$urandom_range(0, n - 1)] = CP_W'($urandom_range(0, MAX_CP));
    end
    down = $urandom_range(1);
    for (i = 0; i < n; i++) begin
      idx = down ? n - 1 - i : i;
      send_word(MODE_WRITE, IDX_W'(idx), layout_vals[idx]);
    end
  endtask

  // mostly stored values, then neighbors, values off either end, and noise
  function automatic logic [CP_W-1:0] pick_codepoint(int n);
    int r;
    int v;
    r = $urandom_range(99);
    if (n == 0 || r >= 90) return CP_W'($urandom_range(0, MAX_CP));
    if (r < 55) return layout_vals[$urandom_range(0, n - 1)];
    if (r < 72) v = int'(layout_vals[$urandom_range(0, n - 1)]) + ($urandom_range(1) ? 1 : -1);
    else if (r < 81) v = int'(sorted_vals[0]) - int'($urandom_range(1, 50));
    else v = int'(sorted_vals[n - 1]) + int'($urandom_range(1, 50));
    if (v < 0) v = 0;
    if (v > MAX_CP) v = MAX_CP;
    return CP_W'(v);
  endfunction

  // lookups right after reset see an empty table
  task automatic test_empty_table();
    send_lookup('0);
    send_lookup(CP_W'(MAX_CP));
  endtask

  // dense run for the direct probe, a gap, the top codepoint, misses below and inside
  task automatic test_sorted_probe();
    int i;
    program_config(5, LAYOUT_SORTED);
    sorted_vals[0] = CP_W'(100);
    sorted_vals[1] = CP_W'(101);
    sorted_vals[2] = CP_W'(102);
    sorted_vals[3] = CP_W'(105);
    sorted_vals[4] = CP_W'(MAX_CP);
    for (i = 0; i < 5; i++) send_word(MODE_WRITE, IDX_W'(i), sorted_vals[i]);
    send_lookup(CP_W'(100));
    send_lookup(CP_W'(102));
    send_lookup(CP_W'(105));
    send_lookup(CP_W'(MAX_CP));
    send_lookup(CP_W'(99));
    send_lookup(CP_W'(103));
    send_lookup('0);
  endtask

  // seven-node tree: root, both extremes, a miss between leaves
  task automatic test_tree_walk();
    int i;
    program_config(7, LAYOUT_TREE);
    sorted_vals[0] = '0;
    sorted_vals[1] = CP_W'('h1000);
    sorted_vals[2] = CP_W'('h2000);
    sorted_vals[3] = CP_W'('h3000);
    sorted_vals[4] = CP_W'('h4000);
    sorted_vals[5] = CP_W'('h8000);
    sorted_vals[6] = CP_W'('h100000);
    arrange_tree(7);
    for (i = 0; i < 7; i++) send_word(MODE_WRITE, IDX_W'(i), layout_vals[i]);
    send_lookup(sorted_vals[3]);
    send_lookup('0);
    send_lookup(CP_W'('h100000));
    send_lookup(CP_W'('h2001));
  endtask

  // full and saturated counts with a short written prefix plus the top entry;
  // lookups are chosen so every probe and walk lands on written entries
  task automatic test_full_count();
    int i;
    int unsigned v;
    int unsigned first_cp;
    int unsigned low_cp;
    send_idle_pct = 0;
    recv_idle_pct = 10;
    program_config(TABLE_DEPTH, LAYOUT_SORTED);
    v = $urandom_range(16, 'h8000);
    first_cp = v;
    for (i = 0; i < FULL_PREFIX; i++) begin
      layout_vals[i] = CP_W'(v);
      v += $urandom_range(1, 2);
      send_word(MODE_WRITE, IDX_W'(i), layout_vals[i]);
    end
    // below the first entry the probe lands on the top entry
    low_cp = first_cp - 1 - $urandom_range(0, 15);
    send_word(MODE_WRITE, IDX_W'(TABLE_DEPTH - 1), CP_W'(low_cp));
    send_lookup(CP_W'(low_cp));
    repeat (12) send_lookup(CP_W'(first_cp + $urandom_range(0, FULL_PREFIX - 1)));
    // far above the first entry the probe also lands on the top entry
    send_word(MODE_WRITE, IDX_W'(TABLE_DEPTH - 1), CP_W'(MAX_CP));
    send_lookup(CP_W'(MAX_CP));
    program_config((1 << CNT_W) - 1, LAYOUT_SORTED);
    send_lookup(CP_W'(MAX_CP));
    repeat (12) send_lookup(CP_W'(first_cp + $urandom_range(0, FULL_PREFIX - 1)));
    // full tree order, only the top levels written, lookups of written nodes
    program_config(TABLE_DEPTH, LAYOUT_TREE);
    v = $urandom_range(0, MAX_CP - TABLE_DEPTH * 128);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      sorted_vals[i] = CP_W'(v);
      v += $urandom_range(1, 128);
    end
    arrange_tree(TABLE_DEPTH);
    for (i = 0; i < FULL_PREFIX; i++) send_word(MODE_WRITE, IDX_W'(i), layout_vals[i]);
    repeat (12) send_lookup(layout_vals[$urandom_range(0, FULL_PREFIX - 1)]);
  endtask

  // hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_config(32, LAYOUT_SORTED);
    load_table(32, 1'b0, 4, 1'b0);
    hold_requests++;
    repeat (24) send_lookup(pick_codepoint(32));
    wait_results_drained();
  endtask

  // one phase: new count and layout, fresh contents, a burst of lookups with occasional overwrites
  task automatic run_random_phase();
    int n;
    int r;
    int j;
    bit tree;
    r = $urandom_range(99);
    if (r < 5) n = 0;
    else if (r < 60) n = $urandom_range(1, 16);
    else if (r < 88) n = $urandom_range(17, 64);
    else n = $urandom_range(65, 300);
    tree = $urandom_range(1);
    program_config(n, tree ? LAYOUT_TREE : LAYOUT_SORTED);
    if (n > 0)
      load_table(n, tree, ($urandom_range(99) < 40) ? 1 : $urandom_range(2, 64),
                 $urandom_range(99) < 15);
    repeat ($urandom_range(12, 40)) begin
      if (n > 0 && $urandom_range(99) < 8) begin
        // overwrite an entry that is already in use
        j = $urandom_range(0, n - 1);
        layout_vals[j] = CP_W'($urandom_range(0, MAX_CP));
        send_word(MODE_WRITE, IDX_W'(j), layout_vals[j]);
      end else begin
        send_lookup(pick_codepoint(n));
      end
    end
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct, int target);
    int unsigned stop_at;
    stop_at = items_sent + target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (items_sent < stop_at) run_random_phase();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ENTRY_COUNT;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_mode        = MODE_WRITE;
    in_entry_index = '0;
    in_codepoint   = '0;
    entry_count_q  = '0;
    layout_q       = LAYOUT_SORTED;
    send_idle_pct  = 10;
    recv_idle_pct  = 25;
    hold_requests  = 0;
    items_sent     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_sorted_probe();
    test_tree_walk();
    test_full_count();
    test_backpressure();
    test_random_traffic(22, 69, 200);
    test_random_traffic(69, 22, 200);
    test_random_traffic(0, 0, 200);

    wait_results_drained();
    repeat (SETTLE_WAIT) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("glyph_codepoint_table_search_top verification clean");
    end else begin
      $display("glyph_codepoint_table_search_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gcts_pkg.sv
sv/gcts_ram.sv
sv/glyph_codepoint_table_search_top.sv
bench/glyph_codepoint_table_search_top_tb.sv
